/* src/xtt_pkg.sv */
// Shared types and constants for the XML tag tokenizer.
package xtt_pkg;

   // Token kinds
   localparam logic [2:0] KIND_ELEMENT   = 3'd0;
   localparam logic [2:0] KIND_ATTR_NAME = 3'd1;
   localparam logic [2:0] KIND_ATTR_VAL  = 3'd2;
   localparam logic [2:0] KIND_TAG_END   = 3'd3;
   localparam logic [2:0] KIND_ERROR     = 3'd4;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_END        = 3'd1;
   localparam logic [2:0] ERR_LABEL      = 3'd2;
   localparam logic [2:0] ERR_INVALID    = 3'd3;
   localparam logic [2:0] ERR_STRING     = 3'd4;
   localparam logic [2:0] ERR_TOO_MANY   = 3'd5;

   // Tag forms
   localparam logic [1:0] FORM_OPEN      = 2'd0;
   localparam logic [1:0] FORM_CLOSE     = 2'd1;
   localparam logic [1:0] FORM_SELF      = 2'd2;

   localparam logic [7:0] MAX_PAIRS_RESET = 8'd15;
   localparam logic [7:0] WS_MAX          = 8'd32;
   localparam logic [7:0] PRINT_MAX       = 8'd126;

   localparam int RSP_DATA_BITS = 80;

   typedef enum logic [4:0] {
      PH_BETWEEN    = 5'd0,
      PH_AFTER_LT   = 5'd1,
      PH_DECL       = 5'd2,
      PH_BANG       = 5'd3,
      PH_BANG2      = 5'd4,
      PH_CBODY      = 5'd5,
      PH_CDASH      = 5'd6,
      PH_CEND       = 5'd7,
      PH_CLOSE_WS   = 5'd8,
      PH_NAME       = 5'd9,
      PH_CLOSE_END  = 5'd10,
      PH_AFTER_NAME = 5'd11,
      PH_ATTR_START = 5'd12,
      PH_ATTR_NAME  = 5'd13,
      PH_EQ_WS      = 5'd14,
      PH_VAL_WS     = 5'd15,
      PH_STRING     = 5'd16,
      PH_AFTER_VAL  = 5'd17,
      PH_SELF_WS    = 5'd18
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [2:0]         token_kind;
      logic [23:0]        token_start;
      logic [23:0]        token_length;
      logic signed [15:0] nesting_depth;
      logic [1:0]         tag_form;
      logic [7:0]         attribute_count;
      logic [2:0]         error_code;
      logic               last_of_run;
   } rsp_item_type;

endpackage

/* src/xtt_parser.sv */
// Tag parser: phase register, counters and per-byte result logic.
module xtt_parser #(
   parameter int POSITION_BITS = 24,
   parameter int DEPTH_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  xtt_pkg::req_item_type item,
   input  logic [7:0]            max_pairs,
   output xtt_pkg::rsp_item_type res0,
   output xtt_pkg::rsp_item_type res1,
   output logic [1:0]            res_count,
   output logic                  halted
);
   import xtt_pkg::*;

   localparam logic signed [DEPTH_BITS-1:0] DMAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DMIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

   phase_type                     phase_ff, phase_in, eff;
   logic [POSITION_BITS-1:0]      pos_ff, begin_ff, begin_in, span;
   logic signed [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [7:0]                    pairs_ff, pairs_in;
   logic                          closing_ff, closing_in;
   logic                          halted_ff, halted_in;

   logic [7:0]   b;
   logic         eof, ws, lstart, lchar;
   logic         pre, do_fail, do_end, do_value;
   logic [2:0]   fail_code, pre_kind;
   logic [1:0]   form;
   rsp_item_type pre_res, main_res;
   logic         main_v;

   assign b      = item.text_byte;
   assign eof    = item.end_of_text | (b == 8'd0);
   assign ws     = !eof && (b <= WS_MAX);
   assign lstart = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   assign lchar  = lstart || (b >= "0" && b <= "9");
   assign span   = pos_ff - begin_ff;

   always_comb begin
      phase_in   = phase_ff;
      begin_in   = begin_ff;
      depth_in   = depth_ff;
      pairs_in   = pairs_ff;
      closing_in = closing_ff;
      halted_in  = halted_ff;
      eff        = phase_ff;
      pre        = 1'b0;
      pre_kind   = KIND_ELEMENT;
      do_fail    = 1'b0;
      do_end     = 1'b0;
      do_value   = 1'b0;
      fail_code  = ERR_NONE;
      form       = FORM_OPEN;

      if (eof) begin
         do_fail   = 1'b1;
         fail_code = (phase_ff >= PH_BANG && phase_ff <= PH_CEND) ? ERR_INVALID : ERR_END;
      end else begin
         // A name ends on the first non-label byte, which is then parsed again
         case (phase_ff)
            PH_NAME: begin
               if (!lchar) begin
                  pre      = 1'b1;
                  pre_kind = KIND_ELEMENT;
                  eff      = closing_ff ? PH_CLOSE_END : PH_AFTER_NAME;
               end
            end
            PH_ATTR_NAME: begin
               if (!lchar) begin
                  pre      = 1'b1;
                  pre_kind = KIND_ATTR_NAME;
                  eff      = PH_EQ_WS;
               end
            end
            PH_AFTER_VAL: begin
               if (!ws && b != "/" && b != ">") eff = PH_ATTR_START;
            end
            default: ;
         endcase
         phase_in = eff;

         unique case (eff)
            PH_AFTER_LT: begin
               if (!ws) begin
                  if (b == "?") phase_in = PH_DECL;
                  else if (b == "!") phase_in = PH_BANG;
                  else if (b == "/") begin
                     closing_in = 1'b1;
                     phase_in   = PH_CLOSE_WS;
                  end else if (lstart) begin
                     begin_in = pos_ff;
                     phase_in = PH_NAME;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_LABEL;
                  end
               end
            end
            PH_DECL: begin
               if (b == ">") phase_in = PH_BETWEEN;
            end
            PH_BANG, PH_BANG2: begin
               if (b == "-") phase_in = (eff == PH_BANG) ? PH_BANG2 : PH_CBODY;
               else begin
                  do_fail   = 1'b1;
                  fail_code = ERR_INVALID;
               end
            end
            PH_CBODY: begin
               if (b == "-") phase_in = PH_CDASH;
            end
            PH_CDASH: begin
               phase_in = (b == "-") ? PH_CEND : PH_CBODY;
            end
            PH_CEND: begin
               if (b == ">") phase_in = PH_BETWEEN;
               else begin
                  do_fail   = 1'b1;
                  fail_code = ERR_INVALID;
               end
            end
            PH_CLOSE_WS: begin
               if (!ws) begin
                  if (lstart) begin
                     begin_in = pos_ff;
                     phase_in = PH_NAME;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_LABEL;
                  end
               end
            end
            PH_NAME, PH_ATTR_NAME: ;
            PH_CLOSE_END: begin
               if (!ws) begin
                  if (b == ">") begin
                     do_end = 1'b1;
                     form   = FORM_CLOSE;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_INVALID;
                  end
               end
            end
            PH_AFTER_NAME: begin
               if (b == "/") phase_in = PH_SELF_WS;
               else if (b == ">") do_end = 1'b1;
               else if (ws) phase_in = PH_ATTR_START;
               else begin
                  do_fail   = 1'b1;
                  fail_code = ERR_LABEL;
               end
            end
            PH_ATTR_START: begin
               if (!ws) begin
                  if (!lstart) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_LABEL;
                  end else if (pairs_ff >= max_pairs) begin
                     do_fail   = 1'b1;
                     fail_code = ERR_TOO_MANY;
                  end else begin
                     begin_in = pos_ff;
                     phase_in = PH_ATTR_NAME;
                  end
               end
            end
            PH_EQ_WS: begin
               if (!ws) begin
                  if (b == "=") phase_in = PH_VAL_WS;
                  else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_INVALID;
                  end
               end
            end
            PH_VAL_WS: begin
               if (!ws) begin
                  if (b == "\"") begin
                     begin_in = pos_ff + 1'b1;
                     phase_in = PH_STRING;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_STRING;
                  end
               end
            end
            PH_STRING: begin
               if (b > PRINT_MAX) begin
                  do_fail   = 1'b1;
                  fail_code = ERR_INVALID;
               end else if (b == "\"") begin
                  do_value = 1'b1;
                  pairs_in = pairs_ff + 8'd1;
                  phase_in = PH_AFTER_VAL;
               end
            end
            PH_AFTER_VAL: begin
               if (b == "/") phase_in = PH_SELF_WS;
               else if (b == ">") do_end = 1'b1;
            end
            PH_SELF_WS: begin
               if (!ws) begin
                  if (b == ">") begin
                     do_end = 1'b1;
                     form   = FORM_SELF;
                  end else begin
                     do_fail   = 1'b1;
                     fail_code = ERR_INVALID;
                  end
               end
            end
            default: begin
               // between tags
               if (ws) phase_in = PH_BETWEEN;
               else if (b == "<") begin
                  closing_in = 1'b0;
                  pairs_in   = 8'd0;
                  phase_in   = PH_AFTER_LT;
               end else begin
                  do_fail   = 1'b1;
                  fail_code = ERR_INVALID;
               end
            end
         endcase
      end

      if (do_end) begin
         if (form == FORM_OPEN && depth_ff != DMAX) depth_in = depth_ff + 1'b1;
         else if (form == FORM_CLOSE && depth_ff != DMIN) depth_in = depth_ff - 1'b1;
         phase_in   = PH_BETWEEN;
         pairs_in   = 8'd0;
         closing_in = 1'b0;
      end
      if (do_fail) halted_in = 1'b1;
   end

   always_comb begin
      pre_res              = '0;
      pre_res.token_kind   = pre_kind;
      pre_res.token_start  = 24'(begin_ff);
      pre_res.token_length = 24'(span);

      main_res = '0;
      main_v   = do_fail | do_end | do_value;
      if (do_fail) begin
         main_res.token_kind  = KIND_ERROR;
         main_res.token_start = 24'(pos_ff);
         main_res.error_code  = fail_code;
      end else if (do_end) begin
         main_res.token_kind      = KIND_TAG_END;
         main_res.token_start     = 24'(pos_ff);
         main_res.token_length    = 24'd1;
         main_res.nesting_depth   = 16'(depth_in);
         main_res.tag_form        = form;
         main_res.attribute_count = pairs_ff;
      end else begin
         main_res.token_kind   = KIND_ATTR_VAL;
         main_res.token_start  = 24'(begin_ff);
         main_res.token_length = 24'(span);
      end
      main_res.last_of_run = 1'b1;

      res0             = pre ? pre_res : main_res;
      res0.last_of_run = !(pre && main_v);
      res1             = main_res;
      res_count        = (fire && !halted_ff) ? ({1'b0, pre} + {1'b0, main_v}) : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_BETWEEN;
         pos_ff     <= '0;
         begin_ff   <= '0;
         depth_ff   <= '0;
         pairs_ff   <= '0;
         closing_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else if (fire && !halted_ff) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_ff + 1'b1;
         begin_ff   <= begin_in;
         depth_ff   <= depth_in;
         pairs_ff   <= pairs_in;
         closing_ff <= closing_in;
         halted_ff  <= halted_in;
      end
   end

   assign halted = halted_ff;

endmodule

/* src/xtt_rsp_fifo.sv */
// Four-entry result queue taking up to two items per cycle.
module xtt_rsp_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            push_count,
   input  xtt_pkg::rsp_item_type push0,
   input  xtt_pkg::rsp_item_type push1,
   output logic                  room,
   output logic [2:0]            level,
   output logic                  out_valid,
   input  logic                  out_ready,
   output xtt_pkg::rsp_item_type out_item
);
   import xtt_pkg::*;

   rsp_item_type mem_ff [4];
   logic [1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [2:0]   level_ff, level_in;
   logic         pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = level_ff != 3'd0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign room      = level_ff <= 3'd2;
   assign level     = level_ff;
   assign level_in  = level_ff + {1'b0, push_count} - {2'b00, pop};

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) mem_ff[wr_ptr_ff] <= push0;
      if (push_count == 2'd2) mem_ff[wr_ptr_ff + 2'd1] <= push1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + push_count;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         level_ff  <= level_in;
      end
   end

endmodule

/* src/xml_tag_tokenizer.sv */
// Top level of the XML tag tokenizer: input register, parser, result queue.
// A byte accepted into the input register is parsed from there, and its results are written
//   into the result queue, whose head drives rsp_.
// Throughput: one byte per cycle. The input stalls only while the result queue holds three
//   or more items, which runs of two-result bytes or rsp_ stalls can cause.
// Reset (synchronous, active high) returns the parser to between tags, position 0.
module xml_tag_tokenizer #(
   parameter int POSITION_BITS = 24,
   parameter int DEPTH_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [xtt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
                                    // [23:0] token_start, [47:24] token_length,
                                    // [63:48] nesting_depth, [65:64] tag_form,
                                    // [73:66] attribute_count, [76:74] error_code
   output logic [2:0]  rsp_tuser,   // [2:0] token_kind
   output logic        rsp_tlast,   // last_of_run
   // Register write: max_attribute_pairs
   input  logic        csr_wen,
   input  logic [7:0]  csr_wdata
);
   import xtt_pkg::*;

   logic          in_valid_ff;
   req_item_type  in_item_ff;
   logic [7:0]    max_pairs_ff;
   logic          fire, room, halted;
   logic [2:0]    level;
   logic [1:0]    res_count;
   rsp_item_type  res0, res1, out_item;

   // The parser consumes the held byte whenever the queue has room for
   // the worst case of two results.
   assign fire       = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.text_byte   <= req_tdata;
         in_item_ff.end_of_text <= req_tlast;
      end
   end

   // Attribute limit, to be written only while idle; the block itself does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         max_pairs_ff <= MAX_PAIRS_RESET;
      end else if (csr_wen) begin
         max_pairs_ff <= csr_wdata;
      end
   end

   xtt_parser #(
      .POSITION_BITS (POSITION_BITS),
      .DEPTH_BITS    (DEPTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (in_item_ff),
      .max_pairs (max_pairs_ff),
      .res0      (res0),
      .res1      (res1),
      .res_count (res_count),
      .halted    (halted)
   );

   xtt_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push0      (res0),
      .push1      (res1),
      .room       (room),
      .level      (level),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = {3'b000, out_item.error_code, out_item.attribute_count,
                       out_item.tag_form, out_item.nesting_depth,
                       out_item.token_length, out_item.token_start};
   assign rsp_tuser = out_item.token_kind;
   assign rsp_tlast = out_item.last_of_run;

   // Results are only pushed when the queue can take both
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (res_count != 2'd0) |-> (level <= 3'd2))
      else $error("result push without queue room");

   // A two-result byte always leads with a name token
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (res_count == 2'd2) |->
      (res0.token_kind == KIND_ELEMENT || res0.token_kind == KIND_ATTR_NAME))
      else $error("two results without a leading name");

   // Once halted, the parser produces nothing more
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halted |-> (res_count == 2'd0))
      else $error("results after halt");

   // An error is always the final result of its byte
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_ERROR) |-> rsp_tlast)
      else $error("error result not last of run");

endmodule
